>>> src/max_heap_priority_queue_top_macros.svh
// assertion macros used by the port-level checker file
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define MHPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> src/mhpq_pkg.sv
// package with types and constants of the heap priority queue
package mhpq_pkg;
  localparam int unsigned Capacity   = 1024;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned AddrWidth  = $clog2(Capacity);
  localparam int unsigned CountWidth = 11;

  localparam logic [1:0] ModePush    = 2'd0;
  localparam logic [1:0] ModePop     = 2'd1;
  localparam logic [1:0] ModeAppend  = 2'd2;
  localparam logic [1:0] ModeHeapify = 2'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic [15:0]           popped_value;
    logic [1:0]            status;
    logic [CountWidth-1:0] count;
    logic                  is_empty;
    logic                  is_full;
  } rsp_t;
endpackage

>>> src/mhpq_ram.sv
// single-port-write, one-read synchronous ram holding the heap entries
module mhpq_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> src/max_heap_priority_queue_top.sv
// top level of the binary max-heap priority queue
// One request at a time; each produces exactly one response. Entries live in a
// 1024 x 16 synchronous ram with one read and one write port, index i stored at
// address i-1. Append, push on an empty heap, push on a full heap, pop on an
// empty heap and heapify of fewer than two entries go straight to the response.
// Push reads the parent, then compares and writes, once per level climbed. Pop
// reads the root and then the last entry, and per level descended reads the left
// child, reads the right child, and compares and moves. Heapify runs a sift-down
// for every parent from the last one to the root.
// The response waits in an output register, no new request is taken until it
// has been delivered.
module max_heap_priority_queue_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mhpq_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mhpq_pkg::rsp_t  out_data_o
);
  import mhpq_pkg::*;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StUpRd  = 11'b00000000010,
    StUpCmp = 11'b00000000100,
    StPopRt = 11'b00000001000,
    StPopLs = 11'b00000010000,
    StDnL   = 11'b00000100000,
    StDnR   = 11'b00001000000,
    StDnCmp = 11'b00010000000,
    StHpRd  = 11'b00100000000,
    StHpLd  = 11'b01000000000,
    StResp  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] idx_q, idx_d;     // 1-based position of the hole
  logic [CountWidth-1:0] hp_q, hp_d;       // heapify parent
  logic [ValueWidth-1:0] x_q, x_d;         // value being sifted
  logic [ValueWidth-1:0] lv_q, lv_d;       // left child value
  logic                  heapify_q, heapify_d;
  rsp_t                  rsp_q, rsp_d;
  logic                  out_valid_q, out_valid_d;

  logic                  we;
  logic [AddrWidth-1:0]  waddr, raddr;
  logic [ValueWidth-1:0] wdata, rdata;

  mhpq_ram #(.Depth(Capacity), .Width(ValueWidth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  function automatic logic [AddrWidth-1:0] addr_of(logic [CountWidth-1:0] i);
    logic [CountWidth-1:0] a;
    a = i - CountWidth'(1);
    return a[AddrWidth-1:0];
  endfunction

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  logic [CountWidth-1:0] child, parent;
  logic                  rgt_wins;
  logic [ValueWidth-1:0] dn_val;
  logic [CountWidth-1:0] dn_idx;
  assign child    = {idx_q[CountWidth-2:0], 1'b0};
  assign parent   = idx_q >> 1;
  assign rgt_wins = lv_q < rdata;
  // larger child, left one on a tie or when there is no right child
  assign dn_val   = (child != count_q && rgt_wins) ? rdata : lv_q;
  assign dn_idx   = (child != count_q && rgt_wins) ? child + CountWidth'(1) : child;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    hp_d        = hp_q;
    x_d         = x_q;
    lv_d        = lv_q;
    heapify_d   = heapify_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = addr_of(idx_q);
    wdata       = x_q;
    raddr       = addr_of(parent);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          rsp_d.popped_value = '0;
          rsp_d.status       = StatusOk;
          x_d                = in_data_i.value;
          case (in_data_i.mode)
            ModePush, ModeAppend: begin
              if (count_q >= CountWidth'(Capacity)) begin
                rsp_d.status = StatusFull;
                state_d      = StResp;
              end else begin
                count_d = count_q + CountWidth'(1);
                idx_d   = count_q + CountWidth'(1);
                if (in_data_i.mode == ModeAppend || count_q == '0) begin
                  we      = 1'b1;
                  waddr   = addr_of(count_q + CountWidth'(1));
                  wdata   = in_data_i.value;
                  state_d = StResp;
                end else begin
                  state_d = StUpRd;
                end
              end
            end
            ModePop: begin
              if (count_q == '0) begin
                rsp_d.status = StatusEmpty;
                state_d      = StResp;
              end else begin
                raddr     = addr_of(CountWidth'(1));
                heapify_d = 1'b0;
                state_d   = StPopRt;
              end
            end
            default: begin
              heapify_d = 1'b1;
              hp_d      = count_q >> 1;
              state_d   = (count_q < CountWidth'(2)) ? StResp : StHpRd;
            end
          endcase
        end
      end
      StUpRd: begin
        raddr   = addr_of(parent);
        state_d = StUpCmp;
      end
      StUpCmp: begin
        if (rdata < x_q) begin
          we    = 1'b1;
          wdata = rdata;
          idx_d = parent;
          if (parent == CountWidth'(1)) begin
            waddr   = addr_of(idx_q);
            state_d = StResp;
            // final placement happens in resp via hole write below
          end else begin
            state_d = StUpRd;
          end
        end else begin
          we      = 1'b1;
          state_d = StResp;
          idx_d   = '0;
        end
      end
      StPopRt: begin
        rsp_d.popped_value = rdata;
        raddr   = addr_of(count_q);
        state_d = StPopLs;
      end
      StPopLs: begin
        x_d     = rdata;
        count_d = count_q - CountWidth'(1);
        idx_d   = CountWidth'(1);
        if (count_q == CountWidth'(1)) begin
          state_d = StResp;
          idx_d   = '0;
        end else begin
          state_d = StDnL;
        end
      end
      StDnL: begin
        if (child > count_q || child == '0) begin
          we = 1'b1;
          idx_d = '0;
          state_d = heapify_q ? StHpRd : StResp;
        end else begin
          raddr   = addr_of(child);
          state_d = StDnR;
        end
      end
      StDnR: begin
        lv_d    = rdata;
        raddr   = addr_of(child + CountWidth'(1));
        state_d = StDnCmp;
      end
      StDnCmp: begin
        if (x_q >= dn_val) begin
          we      = 1'b1;
          idx_d   = '0;
          state_d = heapify_q ? StHpRd : StResp;
        end else begin
          we      = 1'b1;
          wdata   = dn_val;
          idx_d   = dn_idx;
          state_d = StDnL;
        end
      end
      StHpRd: begin
        if (hp_q == '0) begin
          state_d = StResp;
        end else begin
          raddr   = addr_of(hp_q);
          state_d = StHpLd;
        end
      end
      StHpLd: begin
        x_d     = rdata;
        idx_d   = hp_q;
        hp_d    = hp_q - CountWidth'(1);
        state_d = StDnL;
      end
      StResp: begin
        // push that climbed to the root still holds its value
        if (idx_q != '0) begin
          we    = 1'b1;
          waddr = addr_of(idx_q);
          wdata = x_q;
        end
        idx_d              = '0;
        rsp_d.count        = count_q;
        rsp_d.is_empty     = (count_q == '0);
        rsp_d.is_full      = (count_q == CountWidth'(Capacity));
        out_valid_d        = 1'b1;
        state_d            = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      heapify_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      heapify_q   <= heapify_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hp_q  <= hp_d;
    x_q   <= x_d;
    lv_q  <= lv_d;
    rsp_q <= rsp_d;
  end
endmodule

>>> src/mhpq_checker.sv
// port-level checker for the heap priority queue, bound to the top level
`include "max_heap_priority_queue_top_macros.svh"
module mhpq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mhpq_pkg::rsp_t out_data_o
);
  import mhpq_pkg::*;

  rsp_t rsp;
  logic cnt_zero, cnt_full, fail_rsp, in_fire, out_stall;
  assign rsp       = out_data_o;
  assign cnt_zero  = (rsp.count == '0);
  assign cnt_full  = (rsp.count == CountWidth'(Capacity));
  assign fail_rsp  = out_valid_o && (rsp.status != StatusOk);
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  `MHPQ_ASSERT_IMP(a_empty_flag, clk_i, rst_ni, out_valid_o, rsp.is_empty == cnt_zero, "bad is_empty")
  `MHPQ_ASSERT_IMP(a_full_flag, clk_i, rst_ni, out_valid_o, rsp.is_full == cnt_full, "bad is_full")
  `MHPQ_ASSERT_IMP(a_pop_zero, clk_i, rst_ni, fail_rsp, rsp.popped_value == '0, "value on failure")
  `MHPQ_ASSERT_NEXT(a_no_overlap, clk_i, rst_ni, in_fire, !in_ready_o, "taken while busy")
  `MHPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(rsp), "not held")
endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (.*);
